@@ rtl/tiex_pkg.sv @@
// Shared constants for the tiny ISA execute unit: opcodes, word widths and defaults.
// Used by tiex_store, tiny_isa_execute_unit_top and the testbench; depends on nothing.

package tiex_pkg;

   // Default depth of the data store in 32-bit words.
   localparam int DataDepthDefault = 256;

   // Field widths.
   localparam int ByteWidth = 8;
   localparam int WordWidth = 32;
   localparam int PcWidth   = 16;

   // Packed stream widths, padded to whole bytes.
   localparam int ReqDataWidth = 4 * ByteWidth;
   localparam int RspDataWidth = 56;

   // Program counter value that marks a halted machine.
   localparam logic [PcWidth-1:0] HaltPc = 16'hffff;

   // Opcode bytes.
   localparam logic [ByteWidth-1:0] OpAssign = 8'h3d;
   localparam logic [ByteWidth-1:0] OpJump   = 8'h6a;
   localparam logic [ByteWidth-1:0] OpAdd    = 8'h2b;
   localparam logic [ByteWidth-1:0] OpShift  = 8'h3c;

endpackage

@@ rtl/tiex_store.sv @@
// Data store of the tiny ISA execute unit: two registered read ports, one write port.
// Per-word valid bits make unwritten words read as zero; the most recent write is
// forwarded to reads that were issued in the same cycle. Uses tiex_pkg.

module tiex_store #(
   parameter int DEPTH = tiex_pkg::DataDepthDefault,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr_a,
   input  logic [AW-1:0]                  rd_addr_b,
   output logic [tiex_pkg::WordWidth-1:0] rd_data_a,
   output logic [tiex_pkg::WordWidth-1:0] rd_data_b,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [tiex_pkg::WordWidth-1:0] wr_data
);

   logic [tiex_pkg::WordWidth-1:0] mem [DEPTH];
   logic [DEPTH-1:0]               valid_ff;

   logic [tiex_pkg::WordWidth-1:0] raw_a_ff, raw_b_ff;
   logic                           vld_a_ff, vld_b_ff;
   logic [AW-1:0]                  addr_a_ff, addr_b_ff;

   logic                           lw_en_ff;
   logic [AW-1:0]                  lw_addr_ff;
   logic [tiex_pkg::WordWidth-1:0] lw_data_ff;

   // Memory array: one write and two registered reads per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_a_ff  <= mem[rd_addr_a];
         raw_b_ff  <= mem[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
         vld_a_ff  <= valid_ff[rd_addr_a];
         vld_b_ff  <= valid_ff[rd_addr_b];
      end
      if (wr_en) begin
         lw_addr_ff <= wr_addr;
         lw_data_ff <= wr_data;
      end
   end

   // Valid bits and the last-write marker are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         lw_en_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         lw_en_ff          <= 1'b1;
      end
   end

   // The last write always matches memory contents, so forwarding it is safe even
   // when it landed before the read was issued.
   always_comb begin
      if (lw_en_ff && (lw_addr_ff == addr_a_ff)) begin
         rd_data_a = lw_data_ff;
      end else begin
         rd_data_a = vld_a_ff ? raw_a_ff : '0;
      end
      if (lw_en_ff && (lw_addr_ff == addr_b_ff)) begin
         rd_data_b = lw_data_ff;
      end else begin
         rd_data_b = vld_b_ff ? raw_b_ff : '0;
      end
   end

endmodule

@@ rtl/tiny_isa_execute_unit_top.sv @@
// Top level of the tiny ISA execute unit: stream ports, decode, execute and pc logic.
// Instantiates tiex_store; uses tiex_pkg.

// Executes one four-byte instruction per input word and returns one result word per
// instruction: the next pc, the halt flag and data word 0. The unit sustains one
// instruction per clock unless the output stalls. Each instruction reads its two source
// words from the two-read-port data store, then executes and writes back; the write of
// one instruction is forwarded to the reads of the next, and the pc update is made in
// the execute stage. Results sit in an output register; while one waits, a new word is
// taken if the read stage is empty. Reset clears the store at once through per-word
// valid bits; no clearing pass is needed. Store indexes wrap modulo DATA_DEPTH.
// Once halted, the unit ignores further instructions and reports pc 0xffff.

module tiny_isa_execute_unit_top #(
   parameter int DATA_DEPTH = tiex_pkg::DataDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: command [7:0], dest_index [15:8], operand_b [23:16], operand_c [31:24]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tiex_pkg::ReqDataWidth-1:0] req_tdata,
   // rsp_tdata: next_pc [15:0], halted [16], result_word [48:17], zero [55:49]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tiex_pkg::RspDataWidth-1:0] rsp_tdata
);

   localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int BW = tiex_pkg::ByteWidth;
   localparam int WW = tiex_pkg::WordWidth;
   localparam int PW = tiex_pkg::PcWidth;

   // Reduce an 8-bit index modulo the store depth by conditional subtraction.
   function automatic logic [AW-1:0] slot_of(input logic [BW-1:0] raw);
      logic [15:0] v;
      v = {8'd0, raw};
      for (int k = BW - 1; k >= 0; k--) begin
         if (v >= (16'(DATA_DEPTH) << k)) begin
            v = v - (16'(DATA_DEPTH) << k);
         end
      end
      return v[AW-1:0];
   endfunction

   // Input word fields.
   logic [BW-1:0] req_command, req_dest, req_b, req_c;
   assign req_command = req_tdata[BW-1:0];
   assign req_dest    = req_tdata[2*BW-1:BW];
   assign req_b       = req_tdata[3*BW-1:2*BW];
   assign req_c       = req_tdata[4*BW-1:3*BW];

   // Pipeline, architectural and output registers.
   logic          s1_valid_ff;
   logic [BW-1:0] s1_cmd_ff, s1_b_ff, s1_c_ff;
   logic [AW-1:0] s1_dest_ff;
   logic [PW-1:0] pc_ff, pc_in;
   logic          halt_ff, halt_in;
   logic [WW-1:0] word0_ff, word0_in;
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pc_ff;
   logic          rsp_halt_ff;
   logic [WW-1:0] rsp_word_ff;

   logic          req_accept, out_free, advance;
   logic [WW-1:0] src_a, src_b;
   logic          wr_en, does_write;
   logic [WW-1:0] wr_data;
   logic [PW-1:0] pc_step;

   // Handshake: the execute stage moves whenever the output register can take a word.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   tiex_store #(
      .DEPTH(DATA_DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr_a(slot_of(req_b)),
      .rd_addr_b(slot_of(req_c)),
      .rd_data_a(src_a),
      .rd_data_b(src_b),
      .wr_en    (wr_en),
      .wr_addr  (s1_dest_ff),
      .wr_data  (wr_data)
   );

   // Execute stage: compute the write-back value and the next pc.
   always_comb begin
      pc_step    = pc_ff + 16'd1;
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      does_write = 1'b0;
      wr_data    = '0;
      if (!halt_ff) begin
         pc_in = pc_step;
         case (s1_cmd_ff)
            tiex_pkg::OpAssign: begin
               does_write = 1'b1;
               wr_data    = {{(WW-BW){s1_b_ff[BW-1]}}, s1_b_ff};
            end
            tiex_pkg::OpJump: begin
               if ((src_a != '0) && !src_a[WW-1]) begin
                  pc_in = {8'd0, s1_c_ff};
               end
            end
            tiex_pkg::OpAdd: begin
               does_write = 1'b1;
               wr_data    = src_a + src_b;
            end
            tiex_pkg::OpShift: begin
               does_write = 1'b1;
               wr_data    = (s1_c_ff >= 8'd32) ? '0 : (src_a << s1_c_ff[4:0]);
            end
            default: begin
               pc_in = tiex_pkg::HaltPc;
            end
         endcase
         halt_in = (pc_in == tiex_pkg::HaltPc);
      end
   end

   assign wr_en    = advance && does_write;
   assign word0_in = (wr_en && (s1_dest_ff == '0)) ? wr_data : word0_ff;

   // Read stage payload and output register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= req_command;
         s1_dest_ff <= slot_of(req_dest);
         s1_b_ff    <= req_b;
         s1_c_ff    <= req_c;
      end
      if (advance) begin
         rsp_pc_ff   <= pc_in;
         rsp_halt_ff <= halt_in;
         rsp_word_ff <= word0_in;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         word0_ff     <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= pc_in;
            halt_ff      <= halt_in;
            word0_ff     <= word0_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_word_ff, rsp_halt_ff, rsp_pc_ff};

endmodule

@@ tb/tiny_isa_execute_unit_top_test.sv @@
// Self-checking testbench for tiny_isa_execute_unit_top: instructions go in on the req stream,
// and each rsp word is compared with the state predicted from the instruction.
// Depends on tiex_pkg and on the RTL of the execute unit.

module tiny_isa_execute_unit_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreDepth = tiex_pkg::DataDepthDefault;
   localparam int CycleLimit = 400_000;

   // One instruction as packed in req_tdata, command in the lowest byte.
   typedef struct packed {
      logic [tiex_pkg::ByteWidth-1:0] operand_c;
      logic [tiex_pkg::ByteWidth-1:0] operand_b;
      logic [tiex_pkg::ByteWidth-1:0] dest_index;
      logic [tiex_pkg::ByteWidth-1:0] command;
   } instr_type;

   // Machine status reported after each instruction.
   typedef struct packed {
      logic [tiex_pkg::WordWidth-1:0] word0;
      logic                           halted;
      logic [tiex_pkg::PcWidth-1:0]   next_pc;
   } machine_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // req_tdata: command [7:0], dest_index [15:8], operand_b [23:16], operand_c [31:24]
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [tiex_pkg::ReqDataWidth-1:0] req_tdata = '0;
   // rsp_tdata: next_pc [15:0], halted [16], result_word [48:17], zero [55:49]
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tiex_pkg::RspDataWidth-1:0] rsp_tdata;

   instr_type          instr_q[$];
   machine_status_type status_due_q[$];

   // Predicted machine state.
   logic [tiex_pkg::WordWidth-1:0] word_store[StoreDepth];
   logic [tiex_pkg::PcWidth-1:0]   pc_model;
   logic                           halt_model;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  calm_phase = 1'b0;

   tiny_isa_execute_unit_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
   endtask

   // Executes one instruction on the predicted state and queues the status it reports.
   task automatic execute_instr(input instr_type ins);
      logic [tiex_pkg::PcWidth-1:0]   next;
      logic [tiex_pkg::WordWidth-1:0] src_b;
      logic [tiex_pkg::WordWidth-1:0] src_c;
      int                             dest;
      machine_status_type             status;
      if (!halt_model) begin
         next  = pc_model + 16'd1;
         dest  = ins.dest_index % StoreDepth;
         // Both sources are read before the destination is written.
         src_b = word_store[ins.operand_b % StoreDepth];
         src_c = word_store[ins.operand_c % StoreDepth];
         case (ins.command)
            tiex_pkg::OpAssign: begin
               word_store[dest] = {{24{ins.operand_b[7]}}, ins.operand_b};
            end
            tiex_pkg::OpJump: begin
               if (!src_b[tiex_pkg::WordWidth-1] && src_b != '0)
                  next = {8'h00, ins.operand_c};
            end
            tiex_pkg::OpAdd: begin
               word_store[dest] = src_b + src_c;
            end
            tiex_pkg::OpShift: begin
               word_store[dest] = (ins.operand_c >= 8'd32) ? '0 : src_b << ins.operand_c;
            end
            default: begin
               next = tiex_pkg::HaltPc;
            end
         endcase
         pc_model = next;
         if (next == tiex_pkg::HaltPc) halt_model = 1'b1;
      end
      status.next_pc = halt_model ? tiex_pkg::HaltPc : pc_model;
      status.halted  = halt_model;
      status.word0   = word_store[0];
      status_due_q.push_back(status);
   endtask

   function automatic instr_type make_instr(input logic [7:0] cmd, input logic [7:0] dest,
                                            input logic [7:0] src_b, input logic [7:0] src_c);
      instr_type ins;
      ins.command    = cmd;
      ins.dest_index = dest;
      ins.operand_b  = src_b;
      ins.operand_c  = src_c;
      return ins;
   endfunction

   // Store index biased toward a few low words so that reads see earlier writes.
   function automatic logic [7:0] pick_index();
      if ($urandom_range(0, 4) < 3) return 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   // Random legal instruction; jumps can be left out.
   function automatic instr_type random_instr(input bit with_jump);
      instr_type   ins;
      int unsigned pick;
      pick           = $urandom_range(0, with_jump ? 99 : 74);
      ins.dest_index = pick_index();
      ins.operand_b  = 8'($urandom_range(0, 255));
      ins.operand_c  = 8'($urandom_range(0, 255));
      if (pick < 30) begin
         ins.command = tiex_pkg::OpAssign;
      end else if (pick < 55) begin
         ins.command   = tiex_pkg::OpAdd;
         ins.operand_b = pick_index();
         ins.operand_c = pick_index();
      end else if (pick < 75) begin
         ins.command   = tiex_pkg::OpShift;
         ins.operand_b = pick_index();
         if ($urandom_range(0, 5) == 0) ins.operand_c = 8'($urandom_range(32, 255));
         else ins.operand_c = 8'($urandom_range(0, 31));
      end else begin
         ins.command   = tiex_pkg::OpJump;
         ins.operand_b = pick_index();
      end
      return ins;
   endfunction

   // Waits until every queued word has gone in and every status has come back.
   task automatic wait_drained();
      while (instr_q.size() != 0 || req_tvalid || status_due_q.size() != 0)
         @(negedge clock);
   endtask

   // Reset, once, at the start of the run.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Driver: presents queued instructions, with random gaps between words.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (instr_q.size() > 0) begin
            req_tdata  <= instr_q.pop_front();
            req_tvalid <= 1'b1;
            if (!calm_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Every accepted instruction is run through the predictor.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) execute_instr(instr_type'(req_tdata));
   end

   // Monitor: random stall bursts on rsp_tready, and a field check of every status word.
   always @(posedge clock) begin
      machine_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (status_due_q.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_tdata), 64'h0);
            end else begin
               want = status_due_q.pop_front();
               if (rsp_tdata[15:0] !== want.next_pc)
                  report_mismatch("next_pc", 64'(rsp_tdata[15:0]), 64'(want.next_pc));
               if (rsp_tdata[16] !== want.halted)
                  report_mismatch("halted", 64'(rsp_tdata[16]), 64'(want.halted));
               if (rsp_tdata[48:17] !== want.word0)
                  report_mismatch("result_word", 64'(rsp_tdata[48:17]), 64'(want.word0));
               if (rsp_tdata[55:49] !== '0)
                  report_mismatch("padding", 64'(rsp_tdata[55:49]), 64'h0);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus.
   initial begin
      instr_type   ins;
      logic [7:0]  stop_cmd;
      for (int i = 0; i < StoreDepth; i++) word_store[i] = '0;
      pc_model   = '0;
      halt_model = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed part: immediate extremes, jump conditions, shift limits, add overflow.
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h00, 8'h00, 8'h80));   // zero word
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'h00, 8'h7f, 8'hff));
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'hff, 8'h80, 8'h00));
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'h01, 8'hff, 8'h55));
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'h02, 8'h00, 8'haa));
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h11, 8'hff, 8'h10));   // negative
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h22, 8'h00, 8'hff));   // positive
      instr_q.push_back(make_instr(tiex_pkg::OpShift, 8'h03, 8'h00, 8'h00));
      instr_q.push_back(make_instr(tiex_pkg::OpShift, 8'h04, 8'h01, 8'd31));
      instr_q.push_back(make_instr(tiex_pkg::OpShift, 8'h05, 8'h00, 8'd32));  // too far
      instr_q.push_back(make_instr(tiex_pkg::OpShift, 8'h06, 8'h01, 8'hff));
      instr_q.push_back(make_instr(tiex_pkg::OpAdd, 8'h07, 8'h04, 8'h04));    // wraps to zero
      instr_q.push_back(make_instr(tiex_pkg::OpAdd, 8'h08, 8'h01, 8'hff));
      instr_q.push_back(make_instr(tiex_pkg::OpAdd, 8'h00, 8'h00, 8'h00));    // dest is source
      instr_q.push_back(make_instr(tiex_pkg::OpShift, 8'h00, 8'h00, 8'd24));
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h33, 8'h00, 8'h00));
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'h09, 8'h01, 8'h00));
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h44, 8'h09, 8'h00));   // back to zero
      instr_q.push_back(make_instr(tiex_pkg::OpAdd, 8'hff, 8'hff, 8'h01));
      instr_q.push_back(make_instr(tiex_pkg::OpJump, 8'h55, 8'h04, 8'h20));   // most negative
      instr_q.push_back(make_instr(tiex_pkg::OpAssign, 8'h00, 8'h80, 8'h00));

      // Random legal programs.
      for (int i = 0; i < 600; i++) instr_q.push_back(random_instr(1'b1));
      wait_drained();

      // Last part without idling: the machine stops on a halting opcode.
      calm_phase = 1'b1;
      for (int i = 0; i < 30; i++) instr_q.push_back(random_instr(1'b1));
      do stop_cmd = 8'($urandom_range(0, 255));
      while (stop_cmd == tiex_pkg::OpAssign || stop_cmd == tiex_pkg::OpJump ||
             stop_cmd == tiex_pkg::OpAdd || stop_cmd == tiex_pkg::OpShift);
      ins = random_instr(1'b1);
      ins.command = stop_cmd;
      instr_q.push_back(ins);

      // Words after the halt are ignored but still answered.
      instr_q.push_back(instr_type'(32'hffff_ffff));
      instr_q.push_back(instr_type'(32'h0000_0000));
      for (int i = 0; i < 10; i++) instr_q.push_back(instr_type'(32'($urandom())));
      wait_drained();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
